// File: hdl/lfp_pkg.sv
// shared types and constants for the link frame parser
// used by lfp_parse and link_frame_parser_core; no dependencies
package lfp_pkg;

    localparam int SECTOR_BYTES = 512;
    localparam int POS_W        = 10;
    localparam int LEN_W        = 16;
    localparam int OFF_W        = 9;
    localparam int TDATA_W      = 112;

    localparam logic [7:0] SYNC_BYTE = 8'hAA;

    // frame type codes
    localparam logic [7:0] TYPE_CORE_ID  = 8'd1;
    localparam logic [7:0] TYPE_SKIP     = 8'd2;
    localparam logic [7:0] TYPE_JOYPAD   = 8'd3;
    localparam logic [7:0] TYPE_FLOP_WR  = 8'd4;
    localparam logic [7:0] TYPE_FLOP_RD  = 8'd5;
    localparam logic [7:0] TYPE_CD_REQ   = 8'd6;
    localparam logic [7:0] TYPE_TRACE    = 8'd9;

    // byte positions within a frame
    localparam logic [POS_W-1:0] POS_SYNC     = POS_W'(0);
    localparam logic [POS_W-1:0] POS_LEN_HI   = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LEN_LO   = POS_W'(2);
    localparam logic [POS_W-1:0] POS_TYPE     = POS_W'(3);
    localparam logic [POS_W-1:0] POS_PAYLOAD  = POS_W'(4);
    localparam logic [POS_W-1:0] POS_HDR1_END = POS_W'(5);
    localparam logic [POS_W-1:0] POS_HDR2_END = POS_W'(6);
    localparam logic [POS_W-1:0] POS_HDR3_END = POS_W'(7);
    localparam logic [POS_W-1:0] POS_TRACE_0  = POS_W'(5);
    localparam logic [POS_W-1:0] POS_TRACE_END = POS_W'(4 + 1 + 8);
    localparam logic [POS_W-1:0] POS_TRACE_FIN = POS_W'(4 + 8);
    localparam logic [POS_W-1:0] POS_SECTOR_FIN = POS_W'(6 + SECTOR_BYTES - 1);

    typedef enum logic [2:0] {
        KIND_CORE_ID  = 3'd0,
        KIND_JOYPAD   = 3'd1,
        KIND_FLOP_WR  = 3'd2,
        KIND_FLOP_RD  = 3'd3,
        KIND_CD_REQ   = 3'd4,
        KIND_TRACE    = 3'd5
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [7:0]        core_ident;
        logic [15:0]       pad_one;
        logic [15:0]       pad_two;
        logic              drive_sel;
        logic [14:0]       sector_num;
        logic [OFF_W-1:0]  byte_offset;
        logic [7:0]        data_out;
        logic              audio_flag;
        logic [23:0]       block_addr;
        logic [7:0]        trace_label;
        logic              last;
    } res_t;

endpackage

// File: hdl/lfp_parse.sv
// frame state and per-byte decode of the link frame parser
// depends on lfp_pkg
module lfp_parse (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output logic                res_valid,
    output lfp_pkg::res_t       res
);

    logic [lfp_pkg::POS_W-1:0] frame_pos_reg, frame_pos_next;
    logic [lfp_pkg::LEN_W-1:0] frame_len_reg, frame_len_next;
    logic [7:0]                frame_type_reg, frame_type_next;
    logic [7:0]                trace_tag_reg, trace_tag_next;
    logic [7:0]                hdr_reg [3];
    logic [7:0]                hdr_next [3];

    logic [lfp_pkg::POS_W-1:0] pos_inc;
    logic [lfp_pkg::POS_W-1:0] off_floppy;
    logic [lfp_pkg::POS_W-1:0] off_trace;
    logic [lfp_pkg::LEN_W:0]   skip_end;

    assign pos_inc    = frame_pos_reg + lfp_pkg::POS_W'(1);
    assign off_floppy = frame_pos_reg - lfp_pkg::POS_HDR2_END;
    assign off_trace  = frame_pos_reg - lfp_pkg::POS_TRACE_0;
    assign skip_end   = {1'b0, frame_len_reg} + (lfp_pkg::LEN_W + 1)'(2);

    always_comb
    begin
        frame_pos_next  = frame_pos_reg;
        frame_len_next  = frame_len_reg;
        frame_type_next = frame_type_reg;
        trace_tag_next  = trace_tag_reg;
        hdr_next        = hdr_reg;
        res_valid       = 1'b0;
        res             = '0;

        if (frame_pos_reg == lfp_pkg::POS_SYNC)
        begin
            if (rx_byte == lfp_pkg::SYNC_BYTE)
                frame_pos_next = pos_inc;
        end
        else if (frame_pos_reg == lfp_pkg::POS_LEN_HI)
        begin
            frame_len_next = {rx_byte, 8'h00};
            frame_pos_next = pos_inc;
        end
        else if (frame_pos_reg == lfp_pkg::POS_LEN_LO)
        begin
            frame_len_next = {frame_len_reg[15:8], rx_byte};
            frame_pos_next = pos_inc;
        end
        else if (frame_pos_reg == lfp_pkg::POS_TYPE)
        begin
            frame_type_next = rx_byte;
            frame_pos_next  = pos_inc;
        end
        else
        begin
            case (frame_type_reg) inside
                lfp_pkg::TYPE_CORE_ID:
                begin
                    res_valid      = 1'b1;
                    res.kind       = lfp_pkg::KIND_CORE_ID;
                    res.core_ident = rx_byte;
                    frame_pos_next = lfp_pkg::POS_SYNC;
                end
                lfp_pkg::TYPE_SKIP:
                begin
                    if ({7'd0, frame_pos_reg} >= skip_end)
                        frame_pos_next = lfp_pkg::POS_SYNC;
                    else
                        frame_pos_next = pos_inc;
                end
                lfp_pkg::TYPE_JOYPAD, lfp_pkg::TYPE_CD_REQ:
                begin
                    if (frame_pos_reg < lfp_pkg::POS_HDR3_END)
                    begin
                        // positions 4..6 land in slots 0..2
                        hdr_next[frame_pos_reg[1:0]] = rx_byte;
                        frame_pos_next = pos_inc;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        frame_pos_next = lfp_pkg::POS_SYNC;
                        if (frame_type_reg == lfp_pkg::TYPE_JOYPAD)
                        begin
                            res.kind    = lfp_pkg::KIND_JOYPAD;
                            res.pad_one = {hdr_reg[0], hdr_reg[1]};
                            res.pad_two = {hdr_reg[2], rx_byte};
                        end
                        else
                        begin
                            res.kind       = lfp_pkg::KIND_CD_REQ;
                            res.audio_flag = hdr_reg[0][0];
                            res.block_addr = {hdr_reg[1], hdr_reg[2], rx_byte};
                        end
                    end
                end
                lfp_pkg::TYPE_FLOP_WR:
                begin
                    if (frame_pos_reg < lfp_pkg::POS_HDR2_END)
                    begin
                        hdr_next[{1'b0, frame_pos_reg[0]}] = rx_byte;
                        frame_pos_next = pos_inc;
                    end
                    else
                    begin
                        res_valid       = 1'b1;
                        res.kind        = lfp_pkg::KIND_FLOP_WR;
                        res.drive_sel   = hdr_reg[0][7];
                        res.sector_num  = {hdr_reg[0][6:0], hdr_reg[1]};
                        res.byte_offset = off_floppy[lfp_pkg::OFF_W-1:0];
                        res.data_out    = rx_byte;
                        res.last        = (frame_pos_reg == lfp_pkg::POS_SECTOR_FIN);
                        if (res.last)
                            frame_pos_next = lfp_pkg::POS_SYNC;
                        else
                            frame_pos_next = pos_inc;
                    end
                end
                lfp_pkg::TYPE_FLOP_RD:
                begin
                    if (frame_pos_reg < lfp_pkg::POS_HDR1_END)
                    begin
                        hdr_next[0]    = rx_byte;
                        frame_pos_next = pos_inc;
                    end
                    else
                    begin
                        res_valid      = 1'b1;
                        res.kind       = lfp_pkg::KIND_FLOP_RD;
                        res.drive_sel  = hdr_reg[0][7];
                        res.sector_num = {hdr_reg[0][6:0], rx_byte};
                        frame_pos_next = lfp_pkg::POS_SYNC;
                    end
                end
                lfp_pkg::TYPE_TRACE:
                begin
                    if (frame_pos_reg == lfp_pkg::POS_PAYLOAD)
                    begin
                        trace_tag_next = rx_byte;
                        frame_pos_next = pos_inc;
                    end
                    else if (frame_pos_reg < lfp_pkg::POS_TRACE_END)
                    begin
                        res_valid       = 1'b1;
                        res.kind        = lfp_pkg::KIND_TRACE;
                        res.byte_offset = off_trace[lfp_pkg::OFF_W-1:0];
                        res.data_out    = rx_byte;
                        res.trace_label = trace_tag_reg;
                        res.last        = (frame_pos_reg == lfp_pkg::POS_TRACE_FIN);
                        if (res.last)
                            frame_pos_next = lfp_pkg::POS_SYNC;
                        else
                            frame_pos_next = pos_inc;
                    end
                    else
                    begin
                        frame_pos_next = lfp_pkg::POS_SYNC;
                    end
                end
                default:
                begin
                    // unknown type: back to hunting
                    frame_pos_next = lfp_pkg::POS_SYNC;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_pos_reg  <= '0;
            frame_len_reg  <= '0;
            frame_type_reg <= '0;
            trace_tag_reg  <= '0;
        end
        else if (step)
        begin
            frame_pos_reg  <= frame_pos_next;
            frame_len_reg  <= frame_len_next;
            frame_type_reg <= frame_type_next;
            trace_tag_reg  <= trace_tag_next;
        end
    end

    // header bytes are always written before they are read within a frame
    always_ff @(posedge clk)
    begin
        if (step)
            hdr_reg <= hdr_next;
    end

endmodule

// File: hdl/link_frame_parser_core.sv
// link frame parser: input byte register, frame decode, result register
// bytes wait in the input register for a free result slot; results are then registered
// throughput: one byte per cycle unless the result side stalls; each stage holds one item
// reset (rst_n low, asynchronous): both stages empty, parser hunting for the sync byte
// depends on lfp_pkg and lfp_parse
module link_frame_parser_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // rx_byte[7:0]
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [lfp_pkg::TDATA_W-1:0]  m_tdata,   // core_ident, pad_one, pad_two,
                                                    // drive_sel, sector_num, byte_offset,
                                                    // data_out, audio_flag, block_addr,
                                                    // trace_label, zero fill
    output logic [2:0]                   m_tuser,   // kind
    output logic                         m_tlast
);

    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          in_take;
    logic          out_valid_reg;
    lfp_pkg::res_t out_res_reg;
    logic          res_valid;
    lfp_pkg::res_t res;

    // the input stage moves on when the result slot is free or being drained
    assign in_take  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || in_take;

    lfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (in_take),
        .rx_byte   (in_byte_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (in_take)
                out_valid_reg <= res_valid;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_byte_reg <= s_tdata;
        if (in_take && res_valid)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.kind;
    assign m_tlast  = out_res_reg.last;
    assign m_tdata  = {6'd0,
                       out_res_reg.trace_label,
                       out_res_reg.block_addr,
                       out_res_reg.audio_flag,
                       out_res_reg.data_out,
                       out_res_reg.byte_offset,
                       out_res_reg.sector_num,
                       out_res_reg.drive_sel,
                       out_res_reg.pad_two,
                       out_res_reg.pad_one,
                       out_res_reg.core_ident};

    // a held input byte is not lost or changed while the result slot is blocked
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !in_take) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("input stage dropped or changed a stalled item");

    // only floppy write and trace items carry a last flag
    a_last_kind: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tlast) |->
            (m_tuser == lfp_pkg::KIND_FLOP_WR || m_tuser == lfp_pkg::KIND_TRACE))
        else $error("last flag on an item kind that has no data run");

    // no kind beyond trace is ever produced
    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tuser <= lfp_pkg::KIND_TRACE))
        else $error("result kind out of range");

    // trace offsets stay within the eight payload bytes
    a_trace_off: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == lfp_pkg::KIND_TRACE) |->
            (out_res_reg.byte_offset < lfp_pkg::OFF_W'(8)))
        else $error("trace byte offset out of range");

endmodule

// File: test/link_frame_parser_core_tb.sv
// testbench for link_frame_parser_core: random and directed link byte streams,
// predicted results checked item by item; depends on lfp_pkg and the core rtl
`timescale 1ns / 1ps

module link_frame_parser_core_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BYTES = 110;

    typedef logic [7:0] bytes_t[$];

    // m_tdata layout, top of the word first
    typedef struct packed {
        logic [5:0]  fill;
        logic [7:0]  trace_label;
        logic [23:0] block_addr;
        logic        audio_flag;
        logic [7:0]  data_out;
        logic [8:0]  byte_offset;
        logic [14:0] sector_num;
        logic        drive_sel;
        logic [15:0] pad_two;
        logic [15:0] pad_one;
        logic [7:0]  core_ident;
    } bus_word_t;

    class frame_checker;
        lfp_pkg::res_t due_results[$];
        int            errors;
        logic [9:0]    pos;
        logic [15:0]   flen;
        logic [7:0]    ftype;
        logic [7:0]    hdr[3];
        logic [7:0]    tag;

        function new();
            pos = '0;
            flen = '0;
            ftype = '0;
            tag = '0;
            errors = 0;
            foreach (hdr[i])
                hdr[i] = '0;
        endfunction

        task report(string msg);
            errors++;
            $display("error at %0t: %0s", $realtime, msg);
        endtask

        task diff(string name, logic [31:0] got, logic [31:0] want);
            if (got !== want)
                report($sformatf("%0s got %0h, want %0h", name, got, want));
        endtask

        // advance the parser by one accepted byte, queue the result it causes
        function void take_byte(logic [7:0] ch);
            lfp_pkg::res_t r;
            bit            fire;
            bit            fin;
            r = '0;
            fire = 1'b0;
            if (pos == lfp_pkg::POS_SYNC)
            begin
                if (ch == lfp_pkg::SYNC_BYTE)
                    pos = pos + 1'b1;
            end
            else if (pos == lfp_pkg::POS_LEN_HI)
            begin
                flen[15:8] = ch;
                pos = pos + 1'b1;
            end
            else if (pos == lfp_pkg::POS_LEN_LO)
            begin
                flen[7:0] = ch;
                pos = pos + 1'b1;
            end
            else if (pos == lfp_pkg::POS_TYPE)
            begin
                ftype = ch;
                pos = pos + 1'b1;
            end
            else
            begin
                case (ftype)
                    lfp_pkg::TYPE_CORE_ID:
                    begin
                        r.kind = lfp_pkg::KIND_CORE_ID;
                        r.core_ident = ch;
                        fire = 1'b1;
                        pos = '0;
                    end
                    lfp_pkg::TYPE_SKIP:
                    begin
                        if (int'(pos) >= int'(flen) + 2)
                            pos = '0;
                        else
                            pos = pos + 1'b1;
                    end
                    lfp_pkg::TYPE_JOYPAD:
                    begin
                        if (pos < lfp_pkg::POS_HDR3_END)
                        begin
                            hdr[pos[1:0]] = ch;
                            pos = pos + 1'b1;
                        end
                        else
                        begin
                            r.kind = lfp_pkg::KIND_JOYPAD;
                            r.pad_one = {hdr[0], hdr[1]};
                            r.pad_two = {hdr[2], ch};
                            fire = 1'b1;
                            pos = '0;
                        end
                    end
                    lfp_pkg::TYPE_FLOP_WR:
                    begin
                        if (pos < lfp_pkg::POS_HDR2_END)
                        begin
                            hdr[{1'b0, pos[0]}] = ch;
                            pos = pos + 1'b1;
                        end
                        else
                        begin
                            fin = (pos == lfp_pkg::POS_SECTOR_FIN);
                            r.kind = lfp_pkg::KIND_FLOP_WR;
                            r.drive_sel = hdr[0][7];
                            r.sector_num = {hdr[0][6:0], hdr[1]};
                            r.byte_offset = lfp_pkg::OFF_W'(pos - lfp_pkg::POS_HDR2_END);
                            r.data_out = ch;
                            r.last = fin;
                            fire = 1'b1;
                            pos = fin ? '0 : pos + 1'b1;
                        end
                    end
                    lfp_pkg::TYPE_FLOP_RD:
                    begin
                        if (pos < lfp_pkg::POS_HDR1_END)
                        begin
                            hdr[0] = ch;
                            pos = pos + 1'b1;
                        end
                        else
                        begin
                            r.kind = lfp_pkg::KIND_FLOP_RD;
                            r.drive_sel = hdr[0][7];
                            r.sector_num = {hdr[0][6:0], ch};
                            fire = 1'b1;
                            pos = '0;
                        end
                    end
                    lfp_pkg::TYPE_CD_REQ:
                    begin
                        if (pos < lfp_pkg::POS_HDR3_END)
                        begin
                            hdr[pos[1:0]] = ch;
                            pos = pos + 1'b1;
                        end
                        else
                        begin
                            r.kind = lfp_pkg::KIND_CD_REQ;
                            r.audio_flag = hdr[0][0];
                            r.block_addr = {hdr[1], hdr[2], ch};
                            fire = 1'b1;
                            pos = '0;
                        end
                    end
                    lfp_pkg::TYPE_TRACE:
                    begin
                        if (pos == lfp_pkg::POS_PAYLOAD)
                        begin
                            tag = ch;
                            pos = pos + 1'b1;
                        end
                        else if (pos < lfp_pkg::POS_TRACE_END)
                        begin
                            fin = (pos == lfp_pkg::POS_TRACE_FIN);
                            r.kind = lfp_pkg::KIND_TRACE;
                            r.byte_offset = lfp_pkg::OFF_W'(pos - lfp_pkg::POS_TRACE_0);
                            r.data_out = ch;
                            r.trace_label = tag;
                            r.last = fin;
                            fire = 1'b1;
                            pos = fin ? '0 : pos + 1'b1;
                        end
                        else
                        begin
                            pos = '0;
                        end
                    end
                    default: pos = '0;
                endcase
            end
            if (fire)
                due_results.push_back(r);
        endfunction

        task match_result(logic [2:0] kind, logic [lfp_pkg::TDATA_W-1:0] td, logic tl);
            lfp_pkg::res_t want;
            bus_word_t     got;
            if (due_results.size() == 0)
            begin
                report($sformatf("result of kind %0d with nothing pending", kind));
                return;
            end
            want = due_results.pop_front();
            got = td;
            diff("kind", kind, want.kind);
            diff("core_ident", got.core_ident, want.core_ident);
            diff("pad_one", got.pad_one, want.pad_one);
            diff("pad_two", got.pad_two, want.pad_two);
            diff("drive_sel", got.drive_sel, want.drive_sel);
            diff("sector_num", got.sector_num, want.sector_num);
            diff("byte_offset", got.byte_offset, want.byte_offset);
            diff("data_out", got.data_out, want.data_out);
            diff("audio_flag", got.audio_flag, want.audio_flag);
            diff("block_addr", got.block_addr, want.block_addr);
            diff("trace_label", got.trace_label, want.trace_label);
            diff("last", tl, want.last);
        endtask
    endclass

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [7:0]                   s_tdata = '0;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic [lfp_pkg::TDATA_W-1:0]  m_tdata;
    logic [2:0]                   m_tuser;
    logic                         m_tlast;

    frame_checker sb;
    int send_idle = 21;
    int recv_idle = 82;
    int sent = 0;
    int cycles = 0;

    link_frame_parser_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 0;
    end

    // result side: check accepted items, stall at random
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.match_result(m_tuser, m_tdata, m_tlast);
            m_tready <= ($urandom_range(0, 99) >= recv_idle);
        end
    end

    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(0, 99) < send_idle)
        begin
            s_tvalid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < send_idle);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b;
        do
            @(posedge clk);
        while (!s_tready);
        sb.take_byte(b);
        sent++;
    endtask

    function automatic bytes_t rand_bytes(input int n);
        bytes_t q;
        for (int i = 0; i < n; i++)
            q.push_back(8'($urandom));
        return q;
    endfunction

    task automatic send_frame(input logic [7:0] ftype, input logic [15:0] flen,
                              input bytes_t body);
        push_byte(lfp_pkg::SYNC_BYTE);
        push_byte(flen[15:8]);
        push_byte(flen[7:0]);
        push_byte(ftype);
        foreach (body[i])
            push_byte(body[i]);
    endtask

    // payload bytes that make a well-formed frame of this type
    function automatic int body_len(input logic [7:0] ftype, input logic [15:0] flen);
        case (ftype)
            lfp_pkg::TYPE_CORE_ID: return 1;
            lfp_pkg::TYPE_SKIP:    return (flen >= 3) ? int'(flen) - 1 : 1;
            lfp_pkg::TYPE_JOYPAD:  return 4;
            lfp_pkg::TYPE_FLOP_WR: return 2 + lfp_pkg::SECTOR_BYTES;
            lfp_pkg::TYPE_FLOP_RD: return 2;
            lfp_pkg::TYPE_CD_REQ:  return 4;
            lfp_pkg::TYPE_TRACE:   return 9;
            default:               return 1;
        endcase
    endfunction

    task automatic random_frame();
        int          r;
        int          n;
        logic [7:0]  t;
        logic [15:0] fl;
        r = $urandom_range(0, 99);
        fl = 16'($urandom);
        if (r < 12)
            t = lfp_pkg::TYPE_CORE_ID;
        else if (r < 22)
        begin
            t = lfp_pkg::TYPE_SKIP;
            fl = 16'($urandom_range(0, 24));
        end
        else if (r < 38)
            t = lfp_pkg::TYPE_JOYPAD;
        else if (r < 50)
            t = lfp_pkg::TYPE_FLOP_RD;
        else if (r < 64)
            t = lfp_pkg::TYPE_CD_REQ;
        else if (r < 82)
            t = lfp_pkg::TYPE_TRACE;
        else if (r < 88)
            t = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(10, 255));
        else if (r < 94)
        begin
            // raw noise, an odd sync byte may start a stray frame
            n = $urandom_range(1, 4);
            for (int i = 0; i < n; i++)
                push_byte(8'($urandom));
            return;
        end
        else
        begin
            // cut-off frame: the next sync is eaten as payload
            case ($urandom_range(0, 4))
                0: t = lfp_pkg::TYPE_CORE_ID;
                1: t = lfp_pkg::TYPE_JOYPAD;
                2: t = lfp_pkg::TYPE_FLOP_RD;
                3: t = lfp_pkg::TYPE_CD_REQ;
                default: t = lfp_pkg::TYPE_TRACE;
            endcase
            send_frame(t, fl, rand_bytes($urandom_range(0, body_len(t, fl) - 1)));
            return;
        end
        send_frame(t, fl, rand_bytes(body_len(t, fl)));
    endtask

    task automatic random_stretch(input int n);
        int start;
        start = sent;
        while (sent - start < n)
            random_frame();
    endtask

    initial
    begin
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("link_frame_parser_core: mismatch");
        $finish;
    end

    initial
    begin
        sb = new();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed: noise while hunting, most message types at their extremes
        push_byte(8'h00);
        push_byte(8'hFF);
        send_frame(lfp_pkg::TYPE_CORE_ID, 16'hFFFF, '{8'hFF});
        send_frame(lfp_pkg::TYPE_SKIP, 16'h0000, '{8'h55});
        send_frame(lfp_pkg::TYPE_JOYPAD, 16'h0004, '{8'hFF, 8'hFF, 8'h00, 8'h00});
        send_frame(lfp_pkg::TYPE_FLOP_RD, 16'h0002, '{8'hFF, 8'hFF});
        send_frame(lfp_pkg::TYPE_CD_REQ, 16'h0000, '{8'h01, 8'hFF, 8'hFF, 8'hFF});
        send_frame(8'hFF, 16'h0001, '{8'hAA});
        send_frame(lfp_pkg::TYPE_CORE_ID, 16'h0001, '{8'h00});

        send_frame(lfp_pkg::TYPE_FLOP_WR, 16'($urandom),
                   rand_bytes(2 + lfp_pkg::SECTOR_BYTES));
        random_stretch(PHASE_BYTES);

        send_idle = 82;
        recv_idle = 21;
        send_frame(lfp_pkg::TYPE_TRACE, 16'h0009, rand_bytes(9));
        random_stretch(PHASE_BYTES);

        send_idle = 0;
        recv_idle = 0;
        random_stretch(PHASE_BYTES);

        s_tvalid <= 1'b0;
        while (sb.due_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.errors == 0)
            $display("link_frame_parser_core: match");
        else
            $display("link_frame_parser_core: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
hdl/lfp_pkg.sv
hdl/lfp_parse.sv
hdl/link_frame_parser_core.sv
test/link_frame_parser_core_tb.sv
